// ===== hdl/equal_power_stereo_panner_core_assert.svh =====
// assertion macros for the equal-power stereo panner checker
// needs i_clk and i_rst_n in the scope that uses them
`ifndef EQUAL_POWER_STEREO_PANNER_CORE_ASSERT_SVH
`define EQUAL_POWER_STEREO_PANNER_CORE_ASSERT_SVH

// checked while out of reset
`define EPSP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define EPSP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hdl/epsp_pkg.sv =====
// shared types and constants of the equal-power stereo panner
// no dependencies
package epsp_pkg;

    localparam int PAN_BITS  = 16;
    localparam int GAIN_BITS = 15;

    // +1.0 in q2.14
    localparam logic signed [PAN_BITS-1:0] PAN_ONE = 16'sd16384;

    typedef enum logic [1:0] {
        MODE_MONO,
        MODE_FOLD_LEFT,
        MODE_FOLD_RIGHT
    } t_pan_mode;

    typedef struct packed {
        t_pan_mode mode;
        logic      last;
    } t_ctl;

endpackage

// ===== hdl/epsp_pan_map.sv =====
// stage 1: pan clamp, phase mapping and gain table index
// depends on epsp_pkg
module epsp_pan_map #(
    parameter int SAMPLE_BITS     = 16,
    parameter int GAIN_TABLE_BITS = 10
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [SAMPLE_BITS-1:0]          i_left_sample,
    input  logic signed [SAMPLE_BITS-1:0]          i_right_sample,
    input  logic signed [epsp_pkg::PAN_BITS-1:0]   i_pan_value,
    input  logic                                   i_frame_last,
    input  logic                                   i_mono_input,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [SAMPLE_BITS-1:0]          o_left_sample,
    output logic signed [SAMPLE_BITS-1:0]          o_right_sample,
    output logic [GAIN_TABLE_BITS:0]               o_gain_index,
    output epsp_pkg::t_ctl                         o_ctl
);
    import epsp_pkg::*;

    localparam int IdxShift = 15 - GAIN_TABLE_BITS;
    localparam logic [PAN_BITS:0] RoundBias = (PAN_BITS + 1)'(2 ** (14 - GAIN_TABLE_BITS));

    logic signed [PAN_BITS-1:0] pan_clamped;
    logic [PAN_BITS:0]          pan_offset;
    logic [PAN_BITS:0]          phase;
    logic [PAN_BITS:0]          phase_rounded;
    logic                       pan_not_pos;
    logic [GAIN_TABLE_BITS:0]   n_gain_index;
    t_ctl                       n_ctl;

    logic                                r_valid;
    logic signed [SAMPLE_BITS-1:0]       r_left_sample;
    logic signed [SAMPLE_BITS-1:0]       r_right_sample;
    logic [GAIN_TABLE_BITS:0]            r_gain_index;
    t_ctl                                r_ctl;

    always_comb begin
        if (i_pan_value < -PAN_ONE) begin
            pan_clamped = -PAN_ONE;
        end else if (i_pan_value > PAN_ONE) begin
            pan_clamped = PAN_ONE;
        end else begin
            pan_clamped = i_pan_value;
        end
        pan_not_pos = pan_clamped[PAN_BITS-1] || (pan_clamped == '0);
        // pan + 1, 0..32768
        pan_offset  = {pan_clamped[PAN_BITS-1], pan_clamped} + {1'b0, PAN_ONE};

        if (i_mono_input) begin
            phase      = pan_offset;
            n_ctl.mode = MODE_MONO;
        end else if (pan_not_pos) begin
            phase      = {pan_offset[PAN_BITS-1:0], 1'b0};
            n_ctl.mode = MODE_FOLD_LEFT;
        end else begin
            phase      = {pan_clamped[PAN_BITS-1:0], 1'b0};
            n_ctl.mode = MODE_FOLD_RIGHT;
        end
        n_ctl.last    = i_frame_last;
        phase_rounded = phase + RoundBias;
        n_gain_index  = phase_rounded[IdxShift +: GAIN_TABLE_BITS + 1];
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_left_sample  <= i_left_sample;
            r_right_sample <= i_right_sample;
            r_gain_index   <= n_gain_index;
            r_ctl          <= n_ctl;
        end
    end

    assign o_valid        = r_valid;
    assign o_left_sample  = r_left_sample;
    assign o_right_sample = r_right_sample;
    assign o_gain_index   = r_gain_index;
    assign o_ctl          = r_ctl;

endmodule

// ===== hdl/epsp_gain_rom.sv =====
// stage 2: quarter-wave sine rom, sine and cosine gains read on two ports
// depends on epsp_pkg; contents are computed at elaboration
module epsp_gain_rom #(
    parameter int SAMPLE_BITS     = 16,
    parameter int GAIN_TABLE_BITS = 10
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [SAMPLE_BITS-1:0]          i_left_sample,
    input  logic signed [SAMPLE_BITS-1:0]          i_right_sample,
    input  logic [GAIN_TABLE_BITS:0]               i_gain_index,
    input  epsp_pkg::t_ctl                         i_ctl,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [SAMPLE_BITS-1:0]          o_left_sample,
    output logic signed [SAMPLE_BITS-1:0]          o_right_sample,
    output logic [epsp_pkg::GAIN_BITS-1:0]         o_gain_sin,
    output logic [epsp_pkg::GAIN_BITS-1:0]         o_gain_cos,
    output epsp_pkg::t_ctl                         o_ctl
);
    import epsp_pkg::*;

    localparam int TabN = 2 ** GAIN_TABLE_BITS;
    localparam logic [63:0] PiHalfQ30 = 64'd1686629713;

    typedef logic [GAIN_BITS-1:0] t_gain_rom [0:TabN];

    // sin(k/N * pi/2), taylor series to t^13 in q2.30, rounded to q0.15
    function automatic logic [GAIN_BITS-1:0] quarter_sine(input int k);
        logic [63:0]        u;
        logic [63:0]        t;
        logic [63:0]        t2;
        logic [63:0]        term;
        logic [63:0]        prod;
        logic signed [63:0] acc;
        logic [63:0]        g;
        u    = 64'(k) << (30 - GAIN_TABLE_BITS);
        t    = (u * PiHalfQ30) >> 30;
        t2   = (t * t) >> 30;
        term = t;
        acc  = signed'(t);
        for (int n = 1; n <= 6; n++) begin
            prod = (term * t2) >> 30;
            case (n)
                1:       term = prod / 6;
                2:       term = prod / 20;
                3:       term = prod / 42;
                4:       term = prod / 72;
                5:       term = prod / 110;
                default: term = prod / 156;
            endcase
            if (n % 2 == 1) begin
                acc = acc - signed'(term);
            end else begin
                acc = acc + signed'(term);
            end
        end
        if (acc < 0) begin
            acc = '0;
        end
        g = (unsigned'(acc) * 64'd32768 + (64'd1 << 29)) >> 30;
        if (g > 64'd32767) begin
            g = 64'd32767;
        end
        return g[GAIN_BITS-1:0];
    endfunction

    function automatic t_gain_rom build_rom();
        t_gain_rom rom;
        for (int k = 0; k <= TabN; k++) begin
            rom[k] = quarter_sine(k);
        end
        return rom;
    endfunction

    localparam t_gain_rom GainRom = build_rom();

    logic [GAIN_TABLE_BITS:0] cos_index;

    logic                          r_valid;
    logic signed [SAMPLE_BITS-1:0] r_left_sample;
    logic signed [SAMPLE_BITS-1:0] r_right_sample;
    logic [GAIN_BITS-1:0]          r_gain_sin;
    logic [GAIN_BITS-1:0]          r_gain_cos;
    t_ctl                          r_ctl;

    assign cos_index = (GAIN_TABLE_BITS + 1)'(TabN) - i_gain_index;
    assign o_ready   = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_gain_sin     <= GainRom[i_gain_index];
            r_gain_cos     <= GainRom[cos_index];
            r_left_sample  <= i_left_sample;
            r_right_sample <= i_right_sample;
            r_ctl          <= i_ctl;
        end
    end

    assign o_valid        = r_valid;
    assign o_left_sample  = r_left_sample;
    assign o_right_sample = r_right_sample;
    assign o_gain_sin     = r_gain_sin;
    assign o_gain_cos     = r_gain_cos;
    assign o_ctl          = r_ctl;

endmodule

// ===== hdl/epsp_mix.sv =====
// stages 3 and 4: gain multiply with rounding, then fold-in add and saturation
// depends on epsp_pkg
module epsp_mix #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [SAMPLE_BITS-1:0]          i_left_sample,
    input  logic signed [SAMPLE_BITS-1:0]          i_right_sample,
    input  logic [epsp_pkg::GAIN_BITS-1:0]         i_gain_sin,
    input  logic [epsp_pkg::GAIN_BITS-1:0]         i_gain_cos,
    input  epsp_pkg::t_ctl                         i_ctl,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [SAMPLE_BITS-1:0]          o_left_out,
    output logic signed [SAMPLE_BITS-1:0]          o_right_out,
    output logic                                   o_block_last
);
    import epsp_pkg::*;

    localparam int ProdBits = SAMPLE_BITS + GAIN_BITS + 1;
    localparam logic signed [ProdBits-1:0] RoundHalf = ProdBits'(2 ** (GAIN_BITS - 1));
    localparam logic signed [SAMPLE_BITS+1:0] SatMax =
        (SAMPLE_BITS + 2)'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic signed [SAMPLE_BITS+1:0] SatMin = ~SatMax;

    function automatic logic signed [SAMPLE_BITS-1:0] saturate(
        input logic signed [SAMPLE_BITS+1:0] v
    );
        logic signed [SAMPLE_BITS+1:0] c;
        if (v > SatMax) begin
            c = SatMax;
        end else if (v < SatMin) begin
            c = SatMin;
        end else begin
            c = v;
        end
        return c[SAMPLE_BITS-1:0];
    endfunction

    // multiply stage
    logic signed [SAMPLE_BITS-1:0] mul_sample;
    logic signed [ProdBits-1:0]    prod_cos;
    logic signed [ProdBits-1:0]    prod_sin;
    logic signed [ProdBits-1:0]    prod_cos_rnd;
    logic signed [ProdBits-1:0]    prod_sin_rnd;
    logic signed [SAMPLE_BITS:0]   n_scaled_cos;
    logic signed [SAMPLE_BITS:0]   n_scaled_sin;
    logic signed [SAMPLE_BITS-1:0] n_addend_left;
    logic signed [SAMPLE_BITS-1:0] n_addend_right;
    logic                          ready_mul;

    logic                          r_valid_mul;
    logic signed [SAMPLE_BITS:0]   r_scaled_cos;
    logic signed [SAMPLE_BITS:0]   r_scaled_sin;
    logic signed [SAMPLE_BITS-1:0] r_addend_left;
    logic signed [SAMPLE_BITS-1:0] r_addend_right;
    logic                          r_last_mul;

    // sum stage
    logic signed [SAMPLE_BITS+1:0] sum_left;
    logic signed [SAMPLE_BITS+1:0] sum_right;
    logic                          ready_sum;

    logic                          r_valid_sum;
    logic signed [SAMPLE_BITS-1:0] r_left_out;
    logic signed [SAMPLE_BITS-1:0] r_right_out;
    logic                          r_last_sum;

    always_comb begin
        // folding left uses the right sample for both gains
        mul_sample     = (i_ctl.mode == MODE_FOLD_LEFT) ? i_right_sample : i_left_sample;
        n_addend_left  = '0;
        n_addend_right = '0;
        case (i_ctl.mode)
            MODE_FOLD_LEFT:  n_addend_left  = i_left_sample;
            MODE_FOLD_RIGHT: n_addend_right = i_right_sample;
            default: begin
                n_addend_left  = '0;
                n_addend_right = '0;
            end
        endcase
        prod_cos     = ProdBits'(mul_sample) * ProdBits'($signed({1'b0, i_gain_cos}));
        prod_sin     = ProdBits'(mul_sample) * ProdBits'($signed({1'b0, i_gain_sin}));
        prod_cos_rnd = prod_cos + RoundHalf;
        prod_sin_rnd = prod_sin + RoundHalf;
        n_scaled_cos = (SAMPLE_BITS + 1)'(prod_cos_rnd >>> GAIN_BITS);
        n_scaled_sin = (SAMPLE_BITS + 1)'(prod_sin_rnd >>> GAIN_BITS);
    end

    assign ready_sum = !r_valid_sum || i_ready;
    assign ready_mul = !r_valid_mul || ready_sum;
    assign o_ready   = ready_mul;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_mul <= 1'b0;
            r_valid_sum <= 1'b0;
        end else begin
            if (ready_mul) begin
                r_valid_mul <= i_valid;
            end
            if (ready_sum) begin
                r_valid_sum <= r_valid_mul;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_mul && i_valid) begin
            r_scaled_cos   <= n_scaled_cos;
            r_scaled_sin   <= n_scaled_sin;
            r_addend_left  <= n_addend_left;
            r_addend_right <= n_addend_right;
            r_last_mul     <= i_ctl.last;
        end
    end

    always_comb begin
        sum_left  = (SAMPLE_BITS + 2)'(r_addend_left) + (SAMPLE_BITS + 2)'(r_scaled_cos);
        sum_right = (SAMPLE_BITS + 2)'(r_addend_right) + (SAMPLE_BITS + 2)'(r_scaled_sin);
    end

    always_ff @(posedge i_clk) begin
        if (ready_sum && r_valid_mul) begin
            r_left_out  <= saturate(sum_left);
            r_right_out <= saturate(sum_right);
            r_last_sum  <= r_last_mul;
        end
    end

    assign o_valid      = r_valid_sum;
    assign o_left_out   = r_left_out;
    assign o_right_out  = r_right_out;
    assign o_block_last = r_last_sum;

endmodule

// ===== hdl/equal_power_stereo_panner_core.sv =====
// equal-power stereo panner, top level: apb register and four-stage pipeline
// depends on epsp_pkg, epsp_pan_map, epsp_gain_rom, epsp_mix
//
//   channel  direction  handshake            payload
//   input    in         i_valid / o_ready    left, right, pan, frame_last
//   output   out        o_valid / i_ready    left_out, right_out, block_last
//   config   in         psel/penable/pwrite  paddr, pwdata -> prdata
//
// one frame per cycle sustained while the output accepts; four registered stages
// (clamp and index, rom read, gain multiply, fold-in add with saturation)
// each stage holds its own valid bit and loads when empty or when the next
// stage moves, so bubbles close up and a stalled output keeps earlier stages
// filling until every stage holds a word
// synchronous active-low reset empties the pipeline and clears mono_input
module equal_power_stereo_panner_core #(
    parameter int SAMPLE_BITS     = 16,
    parameter int GAIN_TABLE_BITS = 10
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // register port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [2:0]                             paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready,
    // input words
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [SAMPLE_BITS-1:0]          i_left_sample,
    input  logic signed [SAMPLE_BITS-1:0]          i_right_sample,
    input  logic signed [epsp_pkg::PAN_BITS-1:0]   i_pan_value,
    input  logic                                   i_frame_last,
    // output words
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [SAMPLE_BITS-1:0]          o_left_out,
    output logic signed [SAMPLE_BITS-1:0]          o_right_out,
    output logic                                   o_block_last
);
    import epsp_pkg::*;

    // word index of mono_input, the only register; byte address 0
    localparam logic RegMonoInput = 1'b0;

    logic r_mono_input;
    logic cfg_write;
    logic reg_hit;

    // stage 1 -> stage 2
    logic                          map_valid;
    logic                          rom_ready;
    logic signed [SAMPLE_BITS-1:0] map_left;
    logic signed [SAMPLE_BITS-1:0] map_right;
    logic [GAIN_TABLE_BITS:0]      map_index;
    t_ctl                          map_ctl;

    // stage 2 -> stages 3 and 4
    logic                          rom_valid;
    logic                          mix_ready;
    logic signed [SAMPLE_BITS-1:0] rom_left;
    logic signed [SAMPLE_BITS-1:0] rom_right;
    logic [GAIN_BITS-1:0]          rom_gain_sin;
    logic [GAIN_BITS-1:0]          rom_gain_cos;
    t_ctl                          rom_ctl;

    // register port: no wait states, writes land on the access cycle
    assign pready    = 1'b1;
    assign reg_hit   = (paddr[2] == RegMonoInput);
    assign cfg_write = psel && penable && pwrite && pready && reg_hit;
    assign prdata    = reg_hit ? {31'd0, r_mono_input} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mono_input <= 1'b0;
        end else if (cfg_write) begin
            r_mono_input <= pwdata[0];
        end
    end

    // clamp the pan, pick the phase for the mode, round to a table index
    epsp_pan_map #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .GAIN_TABLE_BITS (GAIN_TABLE_BITS)
    ) u_pan_map (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .i_pan_value    (i_pan_value),
        .i_frame_last   (i_frame_last),
        .i_mono_input   (r_mono_input),
        .o_valid        (map_valid),
        .i_ready        (rom_ready),
        .o_left_sample  (map_left),
        .o_right_sample (map_right),
        .o_gain_index   (map_index),
        .o_ctl          (map_ctl)
    );

    // sine at idx and cosine as sine at N - idx, both read the same cycle
    epsp_gain_rom #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .GAIN_TABLE_BITS (GAIN_TABLE_BITS)
    ) u_gain_rom (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (map_valid),
        .o_ready        (rom_ready),
        .i_left_sample  (map_left),
        .i_right_sample (map_right),
        .i_gain_index   (map_index),
        .i_ctl          (map_ctl),
        .o_valid        (rom_valid),
        .i_ready        (mix_ready),
        .o_left_sample  (rom_left),
        .o_right_sample (rom_right),
        .o_gain_sin     (rom_gain_sin),
        .o_gain_cos     (rom_gain_cos),
        .o_ctl          (rom_ctl)
    );

    // two multipliers share one sample operand; the fold-in channel is
    // added after rounding, then both sides saturate into the output register
    epsp_mix #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mix (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (rom_valid),
        .o_ready        (mix_ready),
        .i_left_sample  (rom_left),
        .i_right_sample (rom_right),
        .i_gain_sin     (rom_gain_sin),
        .i_gain_cos     (rom_gain_cos),
        .i_ctl          (rom_ctl),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_left_out     (o_left_out),
        .o_right_out    (o_right_out),
        .o_block_last   (o_block_last)
    );

endmodule

// ===== hdl/epsp_checker.sv =====
// port-level checks for the equal-power stereo panner, bound to the top level
// depends on equal_power_stereo_panner_core_assert.svh
`include "equal_power_stereo_panner_core_assert.svh"

module epsp_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic                          pready,
    input logic [2:0]                    paddr,
    input logic [31:0]                   pwdata,
    input logic [31:0]                   prdata,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic signed [SAMPLE_BITS-1:0] o_left_out,
    input logic signed [SAMPLE_BITS-1:0] o_right_out,
    input logic                          o_block_last
);

    // reset empties the pipeline
    `EPSP_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_valid, "output valid after reset")

    // a write to mono_input reads back on the next cycle
    `EPSP_ASSERT(a_cfg_readback, psel && penable && pwrite && pready && !paddr[2] |=> (paddr[2] || prdata[0] == $past(pwdata[0])), "mono_input readback mismatch")

    // only bit 0 of the register is implemented
    `EPSP_ASSERT(a_cfg_upper_zero, prdata[31:1] == 31'd0, "unused register bits not zero")

    // a refused output word holds
    `EPSP_ASSERT(a_out_hold, o_valid && !i_ready |=> o_valid && $stable(o_left_out) && $stable(o_right_out) && $stable(o_block_last), "output word changed while stalled")

endmodule

bind equal_power_stereo_panner_core epsp_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_epsp_checker (.*);
